// ===== design/distance_send_period_table_macros.svh =====
// Assertion macros used by the send-period table controller.
`ifndef DISTANCE_SEND_PERIOD_TABLE_MACROS_SVH
`define DISTANCE_SEND_PERIOD_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSTP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dstp assertion failed");
`define DSTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dstp assertion failed");
`else
`define DSTP_ASSERT_SAME(label, clk, rst, ante, cons)
`define DSTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/dstp_pkg.sv =====
// Types and constants shared by the send-period table controller and datapath.
`timescale 1ns / 1ps
package dstp_pkg;

   localparam int COORD_W  = 20;
   localparam int DIFF_W   = 21;
   localparam int DSQ_W    = 42;
   localparam int THR_W    = 50;
   localparam int PERIOD_W = 4;
   localparam int OBS_W    = 4;
   localparam int TGT_W    = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam logic [PERIOD_W-1:0] PERIOD_STOP = 4'd0;
   localparam logic [PERIOD_W-1:0] PERIOD_NEAR = 4'd1;

   localparam logic REG_NEAR_DISTANCE_SQ = 1'b0;
   localparam logic REG_MAX_RANGE_SQ     = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SUM,
      ST_CLASSIFY,
      ST_SEARCH,
      ST_DECIDE
   } state_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic     clear_step;
      logic     load;
      logic     square;
      axis_type axis;
      logic     acc_clear;
      logic     acc_add;
      logic     classify;
      logic     search;
      logic     commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic in_range;
      logic middle;
      logic search_done;
      logic changed;
      logic out_free;
   } status_type;

endpackage

// ===== design/dstp_datapath.sv =====
// Datapath: input capture, squared distance, period search, period table and result register.
`timescale 1ns / 1ps
module dstp_datapath #(
   parameter int OBSERVERS   = 16,
   parameter int OBSERVABLES = 256,
   parameter int MAX_PERIOD  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dstp_pkg::cmd_type                  cmd,
   output dstp_pkg::status_type               stat,
   input  logic [dstp_pkg::DSQ_W-1:0]         near_distance_sq,
   input  logic [dstp_pkg::DSQ_W-1:0]         max_range_sq,
   input  logic [dstp_pkg::OBS_W-1:0]         req_observer_index,
   input  logic [dstp_pkg::TGT_W-1:0]         req_observable_id,
   input  logic                               req_visible,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_observer_x,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_observer_y,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_observer_z,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_target_x,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_target_y,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_target_z,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [dstp_pkg::OBS_W-1:0]         rsp_changed_observer,
   output logic [dstp_pkg::TGT_W-1:0]         rsp_changed_target,
   output logic [dstp_pkg::PERIOD_W-1:0]      rsp_new_period
);

   localparam int DEPTH  = OBSERVERS * OBSERVABLES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [dstp_pkg::PERIOD_W-1:0] table_mem [DEPTH];

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] req_addr;
   logic [31:0]       idx_wide;
   logic [dstp_pkg::PERIOD_W-1:0] rd_ff;

   logic [dstp_pkg::OBS_W-1:0] obs_ff;
   logic [dstp_pkg::TGT_W-1:0] tgt_ff;
   logic                       vis_ff;
   logic signed [dstp_pkg::COORD_W-1:0] ox_ff, oy_ff, oz_ff, tx_ff, ty_ff, tz_ff;

   logic signed [dstp_pkg::COORD_W-1:0] sel_o, sel_t;
   logic signed [dstp_pkg::DIFF_W-1:0]  diff;
   logic signed [dstp_pkg::DSQ_W-1:0]   sq;
   logic [dstp_pkg::DSQ_W-1:0] prod_ff;
   logic [dstp_pkg::DSQ_W-1:0] acc_ff;

   logic [dstp_pkg::PERIOD_W-1:0] period_ff;
   logic [dstp_pkg::PERIOD_W-1:0] k_ff;
   logic [dstp_pkg::THR_W-1:0]    thr_ff;
   logic [dstp_pkg::THR_W-1:0]    step_ff;
   logic [dstp_pkg::THR_W-1:0]    near_ext;
   logic [dstp_pkg::THR_W-1:0]    acc_ext;
   logic below_near, above_max;

   logic                          rsp_valid_ff;
   logic [dstp_pkg::OBS_W-1:0]    rsp_obs_ff;
   logic [dstp_pkg::TGT_W-1:0]    rsp_tgt_ff;
   logic [dstp_pkg::PERIOD_W-1:0] rsp_period_ff;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [dstp_pkg::PERIOD_W-1:0] wr_data;

   assign idx_wide = 32'(req_observer_index) * 32'(OBSERVABLES) + 32'(req_observable_id);
   assign req_addr = idx_wide[ADDR_W-1:0];
   assign clr_in   = clr_ff + ADDR_W'(1);

   always_comb begin
      case (cmd.axis)
         dstp_pkg::AXIS_X: begin
            sel_o = ox_ff;
            sel_t = tx_ff;
         end
         dstp_pkg::AXIS_Y: begin
            sel_o = oy_ff;
            sel_t = ty_ff;
         end
         default: begin
            sel_o = oz_ff;
            sel_t = tz_ff;
         end
      endcase
   end

   assign diff = dstp_pkg::DIFF_W'(sel_o) - dstp_pkg::DIFF_W'(sel_t);
   assign sq   = dstp_pkg::DSQ_W'(diff) * dstp_pkg::DSQ_W'(diff);

   assign near_ext   = dstp_pkg::THR_W'(near_distance_sq);
   assign acc_ext    = dstp_pkg::THR_W'(acc_ff);
   assign below_near = acc_ff < near_distance_sq;
   assign above_max  = acc_ff > max_range_sq;

   assign stat.clear_done  = clr_ff == ADDR_W'(DEPTH - 1);
   assign stat.in_range    = (32'(req_observer_index) < 32'(OBSERVERS)) &&
                             (32'(req_observable_id) < 32'(OBSERVABLES));
   assign stat.middle      = vis_ff && !below_near && !above_max;
   assign stat.search_done = (acc_ext <= thr_ff) ||
                             (k_ff == dstp_pkg::PERIOD_W'(MAX_PERIOD));
   assign stat.changed     = period_ff != rd_ff;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   assign wr_en   = cmd.clear_step || cmd.commit;
   assign wr_addr = cmd.clear_step ? clr_ff : addr_ff;
   assign wr_data = cmd.clear_step ? dstp_pkg::PERIOD_STOP : period_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (cmd.load) begin
         rd_ff <= table_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_addr;
         obs_ff  <= req_observer_index;
         tgt_ff  <= req_observable_id;
         vis_ff  <= req_visible;
         ox_ff   <= req_observer_x;
         oy_ff   <= req_observer_y;
         oz_ff   <= req_observer_z;
         tx_ff   <= req_target_x;
         ty_ff   <= req_target_y;
         tz_ff   <= req_target_z;
      end
      if (cmd.square) begin
         prod_ff <= sq;
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.classify) begin
         if (!vis_ff) begin
            period_ff <= dstp_pkg::PERIOD_STOP;
         end else if (below_near) begin
            period_ff <= dstp_pkg::PERIOD_NEAR;
         end else begin
            period_ff <= dstp_pkg::PERIOD_STOP;
         end
         k_ff    <= dstp_pkg::PERIOD_NEAR;
         thr_ff  <= near_ext;
         step_ff <= near_ext + (near_ext << 1);
      end else if (cmd.search) begin
         if (stat.search_done) begin
            period_ff <= k_ff;
         end else begin
            k_ff    <= k_ff + dstp_pkg::PERIOD_W'(1);
            thr_ff  <= thr_ff + step_ff;
            step_ff <= step_ff + (near_ext << 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_obs_ff    <= obs_ff;
         rsp_tgt_ff    <= tgt_ff;
         rsp_period_ff <= period_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_changed_observer = rsp_obs_ff;
   assign rsp_changed_target   = rsp_tgt_ff;
   assign rsp_new_period       = rsp_period_ff;

endmodule

// ===== design/dstp_ctrl.sv =====
// Controller state machine sequencing the table clear, distance, period search and commit.
`timescale 1ns / 1ps
`include "distance_send_period_table_macros.svh"
module dstp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dstp_pkg::status_type stat,
   output dstp_pkg::cmd_type    cmd
);

   dstp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dstp_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.axis  = dstp_pkg::AXIS_X;
      req_ready = 1'b0;
      unique case (state_ff)
         dstp_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = dstp_pkg::ST_IDLE;
            end
         end
         dstp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && stat.in_range) begin
               state_in = dstp_pkg::ST_SQ_X;
            end
         end
         dstp_pkg::ST_SQ_X: begin
            cmd.square    = 1'b1;
            cmd.axis      = dstp_pkg::AXIS_X;
            cmd.acc_clear = 1'b1;
            state_in      = dstp_pkg::ST_SQ_Y;
         end
         dstp_pkg::ST_SQ_Y: begin
            cmd.square  = 1'b1;
            cmd.axis    = dstp_pkg::AXIS_Y;
            cmd.acc_add = 1'b1;
            state_in    = dstp_pkg::ST_SQ_Z;
         end
         dstp_pkg::ST_SQ_Z: begin
            cmd.square  = 1'b1;
            cmd.axis    = dstp_pkg::AXIS_Z;
            cmd.acc_add = 1'b1;
            state_in    = dstp_pkg::ST_SUM;
         end
         dstp_pkg::ST_SUM: begin
            cmd.acc_add = 1'b1;
            state_in    = dstp_pkg::ST_CLASSIFY;
         end
         dstp_pkg::ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in = stat.middle ? dstp_pkg::ST_SEARCH : dstp_pkg::ST_DECIDE;
         end
         dstp_pkg::ST_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.search_done) begin
               state_in = dstp_pkg::ST_DECIDE;
            end
         end
         dstp_pkg::ST_DECIDE: begin
            if (!stat.changed) begin
               state_in = dstp_pkg::ST_IDLE;
            end else if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = dstp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dstp_pkg::ST_IDLE;
         end
      endcase
   end

   `DSTP_ASSERT_SAME(a_commit_only_when_free_and_changed, clock, reset, cmd.commit, stat.out_free && stat.changed)
   `DSTP_ASSERT_NEXT(a_clear_runs_to_end, clock, reset, state_ff == dstp_pkg::ST_CLEAR && !stat.clear_done, state_ff == dstp_pkg::ST_CLEAR)
   `DSTP_ASSERT_NEXT(a_out_of_range_ignored, clock, reset, req_valid && req_ready && !stat.in_range, state_ff == dstp_pkg::ST_IDLE)

endmodule

// ===== design/distance_send_period_table.sv =====
// Top level: APB-style register port, send-period controller and datapath.
// An in-range word accepted in IDLE passes SQ_X, SQ_Y, SQ_Z, SUM, CLASSIFY, the period
// search and DECIDE before the next can be accepted; the search, one threshold step a cycle,
// is skipped for hidden, near and far pairs. DECIDE commits a changed period to rsp_valid
// once the response register is free. After reset all OBSERVERS * OBSERVABLES table entries
// (4096 by default) are cleared one a cycle, req_ready low; CSR writes are taken throughout.
`timescale 1ns / 1ps
module distance_send_period_table #(
   parameter int OBSERVERS   = 16,
   parameter int OBSERVABLES = 256,
   parameter int MAX_PERIOD  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dstp_pkg::OBS_W-1:0]          req_observer_index,
   input  logic [dstp_pkg::TGT_W-1:0]          req_observable_id,
   input  logic                                req_visible,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_observer_x,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_observer_y,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_observer_z,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_target_x,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_target_y,
   input  logic signed [dstp_pkg::COORD_W-1:0] req_target_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dstp_pkg::OBS_W-1:0]          rsp_changed_observer,
   output logic [dstp_pkg::TGT_W-1:0]          rsp_changed_target,
   output logic [dstp_pkg::PERIOD_W-1:0]       rsp_new_period,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dstp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dstp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dstp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [dstp_pkg::DSQ_W-1:0] near_ff;
   logic [dstp_pkg::DSQ_W-1:0] max_ff;
   logic                       csr_write;
   logic                       csr_index;

   dstp_pkg::cmd_type    cmd;
   dstp_pkg::status_type stat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= dstp_pkg::DSQ_W'(256);
         max_ff  <= '1;
      end else if (csr_write) begin
         if (csr_index == dstp_pkg::REG_NEAR_DISTANCE_SQ) begin
            near_ff <= csr_pwdata[dstp_pkg::DSQ_W-1:0];
         end else begin
            max_ff <= csr_pwdata[dstp_pkg::DSQ_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (csr_index)
         dstp_pkg::REG_NEAR_DISTANCE_SQ: csr_prdata = dstp_pkg::CSR_DATA_W'(near_ff);
         dstp_pkg::REG_MAX_RANGE_SQ:     csr_prdata = dstp_pkg::CSR_DATA_W'(max_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   dstp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dstp_datapath #(
      .OBSERVERS   (OBSERVERS),
      .OBSERVABLES (OBSERVABLES),
      .MAX_PERIOD  (MAX_PERIOD)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .near_distance_sq     (near_ff),
      .max_range_sq         (max_ff),
      .req_observer_index   (req_observer_index),
      .req_observable_id    (req_observable_id),
      .req_visible          (req_visible),
      .req_observer_x       (req_observer_x),
      .req_observer_y       (req_observer_y),
      .req_observer_z       (req_observer_z),
      .req_target_x         (req_target_x),
      .req_target_y         (req_target_y),
      .req_target_z         (req_target_z),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_changed_observer (rsp_changed_observer),
      .rsp_changed_target   (rsp_changed_target),
      .rsp_new_period       (rsp_new_period)
   );

endmodule

// ===== bench/distance_send_period_table_tb.sv =====
// Self-checking testbench for the send-period table with a scoreboard and random traffic.
`timescale 1ns / 1ps
module distance_send_period_table_tb;

   localparam int OBSERVERS   = 16;
   localparam int OBSERVABLES = 256;
   localparam int MAX_PERIOD  = 8;
   localparam int TABLE_DEPTH = OBSERVERS * OBSERVABLES;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 30;
   localparam int HOLD_CYCLES     = 400;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 92;
   localparam int POOL_SIZE       = 6;

   localparam logic [63:0] MASK42 = 64'h3FF_FFFF_FFFF;
   localparam logic [dstp_pkg::COORD_W-1:0] COORD_MIN = 20'h80000;
   localparam logic [dstp_pkg::COORD_W-1:0] COORD_MAX = 20'h7FFFF;

   localparam int PRESSURE_NONE = 0;
   localparam int HOLD_RECEIVER = 1;
   localparam int DRAIN_SENDER  = 2;

   localparam logic [1:0] STALL_NONE     = 2'd0;
   localparam logic [1:0] STALL_COIN     = 2'd1;
   localparam logic [1:0] STALL_RHYTHM   = 2'd2;
   localparam logic [1:0] STALL_SOMETIME = 2'd3;

   typedef struct packed {
      logic [dstp_pkg::OBS_W-1:0]            observer;
      logic [dstp_pkg::TGT_W-1:0]            target;
      logic                                  visible;
      logic [2:0][dstp_pkg::COORD_W-1:0]     observer_pos;
      logic [2:0][dstp_pkg::COORD_W-1:0]     target_pos;
   } request_type;

   typedef struct packed {
      logic [dstp_pkg::OBS_W-1:0]    observer;
      logic [dstp_pkg::TGT_W-1:0]    target;
      logic [dstp_pkg::PERIOD_W-1:0] period;
   } change_word_type;

   class period_table_scoreboard;
      logic [63:0]                   near_sq;
      logic [63:0]                   max_sq;
      logic [dstp_pkg::PERIOD_W-1:0] stored_period [TABLE_DEPTH];
      change_word_type               pending_changes [$];
      int                            requests_seen;
      int                            changes_checked;
      int                            mismatches;

      function new();
         near_sq = 64'd256;
         max_sq = MASK42;
         foreach (stored_period[i]) stored_period[i] = dstp_pkg::PERIOD_STOP;
         requests_seen = 0;
         changes_checked = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic idx, logic [63:0] value);
         if (idx == dstp_pkg::REG_NEAR_DISTANCE_SQ) begin
            near_sq = value & MASK42;
         end else begin
            max_sq = value & MASK42;
         end
      endfunction

      function logic [dstp_pkg::PERIOD_W-1:0] choose_period(logic [63:0] dsq);
         if (dsq < near_sq) return dstp_pkg::PERIOD_NEAR;
         if (dsq > max_sq) return dstp_pkg::PERIOD_STOP;
         for (int k = 1; k <= MAX_PERIOD; k++) begin
            if (dsq <= 64'(k * k) * near_sq) return dstp_pkg::PERIOD_W'(k);
         end
         return dstp_pkg::PERIOD_W'(MAX_PERIOD);
      endfunction

      function void note_request(request_type r);
         logic [63:0]                   dsq;
         logic [dstp_pkg::PERIOD_W-1:0] period;
         longint                        d;
         int                            slot;
         change_word_type               word;
         requests_seen++;
         if (r.observer >= OBSERVERS || r.target >= OBSERVABLES) return;
         slot = int'(r.observer) * OBSERVABLES + int'(r.target);
         dsq = 64'd0;
         for (int a = 0; a < 3; a++) begin
            d = longint'($signed(r.observer_pos[a])) - longint'($signed(r.target_pos[a]));
            dsq += 64'(d * d);
         end
         period = r.visible ? choose_period(dsq) : dstp_pkg::PERIOD_STOP;
         if (period != stored_period[slot]) begin
            stored_period[slot] = period;
            word.observer = r.observer;
            word.target = r.target;
            word.period = period;
            pending_changes.push_back(word);
         end
      endfunction

      task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
         $display("ERROR %0t: %s got %0d, expected %0d", $time, field, got, want);
         mismatches++;
      endtask

      task check_change(logic [dstp_pkg::OBS_W-1:0] observer,
                        logic [dstp_pkg::TGT_W-1:0] target,
                        logic [dstp_pkg::PERIOD_W-1:0] period);
         change_word_type want;
         if (pending_changes.size() == 0) begin
            report_mismatch("unexpected change word, new_period", period, 0);
            return;
         end
         want = pending_changes.pop_front();
         changes_checked++;
         if (observer !== want.observer)
            report_mismatch("changed_observer", observer, want.observer);
         if (target !== want.target)
            report_mismatch("changed_target", target, want.target);
         if (period !== want.period)
            report_mismatch("new_period", period, want.period);
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [dstp_pkg::OBS_W-1:0]      req_observer_index;
   logic [dstp_pkg::TGT_W-1:0]      req_observable_id;
   logic                            req_visible;
   logic [dstp_pkg::COORD_W-1:0]    req_observer_x;
   logic [dstp_pkg::COORD_W-1:0]    req_observer_y;
   logic [dstp_pkg::COORD_W-1:0]    req_observer_z;
   logic [dstp_pkg::COORD_W-1:0]    req_target_x;
   logic [dstp_pkg::COORD_W-1:0]    req_target_y;
   logic [dstp_pkg::COORD_W-1:0]    req_target_z;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [dstp_pkg::OBS_W-1:0]      rsp_changed_observer;
   logic [dstp_pkg::TGT_W-1:0]      rsp_changed_target;
   logic [dstp_pkg::PERIOD_W-1:0]   rsp_new_period;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [dstp_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [dstp_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [dstp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   period_table_scoreboard board = new();

   logic                       hold_request = 1'b0;
   int                         hold_count = 0;
   int unsigned                rx_tick = 0;
   int                         cycle_count = 0;
   longint                     span;
   logic [dstp_pkg::OBS_W-1:0] pool_observer [POOL_SIZE];
   logic [dstp_pkg::TGT_W-1:0] pool_target [POOL_SIZE];

   distance_send_period_table i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_observer_index   (req_observer_index),
      .req_observable_id    (req_observable_id),
      .req_visible          (req_visible),
      .req_observer_x       (req_observer_x),
      .req_observer_y       (req_observer_y),
      .req_observer_z       (req_observer_z),
      .req_target_x         (req_target_x),
      .req_target_y         (req_target_y),
      .req_target_z         (req_target_z),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_changed_observer (rsp_changed_observer),
      .rsp_changed_target   (rsp_changed_target),
      .rsp_new_period       (rsp_new_period),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("distance_send_period_table: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      if (hold_request && hold_count < HOLD_CYCLES) begin
         rsp_ready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         case (2'((rx_tick / 97) % 4))
            STALL_NONE:   rsp_ready <= 1'b1;
            STALL_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
            STALL_RHYTHM: rsp_ready <= (rx_tick % 5 == 0);
            default:      rsp_ready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_change(rsp_changed_observer, rsp_changed_target, rsp_new_period);
   end

   function automatic longint isqrt(logic [63:0] v);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = longint'(1) << 22;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (64'(mid * mid) <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic request_type make_req(int observer, int target, int visible,
                                            int ox, int oy, int oz,
                                            int tx, int ty, int tz);
      request_type r;
      r.observer = dstp_pkg::OBS_W'(observer);
      r.target = dstp_pkg::TGT_W'(target);
      r.visible = (visible != 0);
      r.observer_pos[0] = dstp_pkg::COORD_W'(ox);
      r.observer_pos[1] = dstp_pkg::COORD_W'(oy);
      r.observer_pos[2] = dstp_pkg::COORD_W'(oz);
      r.target_pos[0] = dstp_pkg::COORD_W'(tx);
      r.target_pos[1] = dstp_pkg::COORD_W'(ty);
      r.target_pos[2] = dstp_pkg::COORD_W'(tz);
      return r;
   endfunction

   // Most words reuse a few pairs so that periods repeat and change, and most
   // offsets are sized from the near distance so that every period band is hit.
   function automatic request_type random_request();
      request_type r;
      int          shape;
      int          axis;
      int          slot;
      longint      off;
      if ($urandom_range(0, 9) < 7) begin
         slot = $urandom_range(0, POOL_SIZE - 1);
         r.observer = pool_observer[slot];
         r.target = pool_target[slot];
      end else begin
         r.observer = dstp_pkg::OBS_W'($urandom);
         r.target = dstp_pkg::TGT_W'($urandom);
      end
      r.visible = ($urandom_range(0, 99) < 85);
      shape = $urandom_range(0, 9);
      axis = $urandom_range(0, 2);
      for (int a = 0; a < 3; a++) begin
         r.observer_pos[a] = dstp_pkg::COORD_W'($urandom);
         if ($urandom_range(0, 15) == 0)
            r.observer_pos[a] = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
         if (shape == 0) begin
            off = longint'($signed(dstp_pkg::COORD_W'($urandom)));
         end else if (shape < 5) begin
            off = (a == axis) ? span * longint'($urandom_range(0, 9))
                                + longint'($urandom_range(0, 2)) - 1 : 0;
         end else begin
            off = longint'($urandom_range(0, 3 * int'(span)));
         end
         if ($urandom_range(0, 1) == 1) off = -off;
         r.target_pos[a] = dstp_pkg::COORD_W'(longint'($signed(r.observer_pos[a])) + off);
      end
      return r;
   endfunction

   task automatic send_request(request_type r);
      @(negedge clock);
      req_valid = 1'b1;
      req_observer_index = r.observer;
      req_observable_id = r.target;
      req_visible = r.visible;
      req_observer_x = r.observer_pos[0];
      req_observer_y = r.observer_pos[1];
      req_observer_z = r.observer_pos[2];
      req_target_x = r.target_pos[0];
      req_target_y = r.target_pos[1];
      req_target_z = r.target_pos[2];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic idle_gap(int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_for_changes();
      while (board.pending_changes.size() != 0) @(posedge clock);
   endtask

   task automatic csr_cycle(logic write, logic idx, logic [63:0] value);
      logic [63:0] want;
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = write;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (write) begin
         board.set_register(idx, value);
      end else begin
         want = (idx == dstp_pkg::REG_NEAR_DISTANCE_SQ) ? board.near_sq : board.max_sq;
         if ((csr_prdata & MASK42) !== want)
            board.report_mismatch("register read", csr_prdata, want);
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic write_register(logic idx, logic [63:0] value);
      csr_cycle(1'b1, idx, value);
      csr_cycle(1'b0, idx, 64'd0);
   endtask

   task automatic run_random(int count, int pressure);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_request(random_request());
            sent++;
            if (sent == count / 2 && pressure == HOLD_RECEIVER) hold_request = 1'b1;
            if (sent == count / 2 && pressure == DRAIN_SENDER) begin
               idle_gap(1);
               wait_for_changes();
            end
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
      idle_gap(1);
   endtask

   initial begin
      logic [63:0] near_setting [PHASES];
      logic [63:0] range_setting [PHASES];
      int          pressure_of [PHASES];
      reset = 1'b1;
      req_valid = 1'b0;
      req_observer_index = '0;
      req_observable_id = '0;
      req_visible = 1'b0;
      req_observer_x = '0;
      req_observer_y = '0;
      req_observer_z = '0;
      req_target_x = '0;
      req_target_y = '0;
      req_target_z = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_observer[i] = dstp_pkg::OBS_W'($urandom);
         pool_target[i] = dstp_pkg::TGT_W'($urandom);
      end
      near_setting[0] = 64'd256;
      range_setting[0] = MASK42;
      near_setting[1] = 64'd2304;
      range_setting[1] = 64'd2304 * 30;
      near_setting[2] = 64'd1;
      range_setting[2] = MASK42;
      near_setting[3] = MASK42;
      range_setting[3] = MASK42;
      near_setting[4] = 64'd0;
      range_setting[4] = MASK42;
      near_setting[5] = 64'($urandom_range(1, 1 << 24));
      range_setting[5] = near_setting[5] * $urandom_range(1, 70);
      near_setting[6] = 64'd200000;
      range_setting[6] = 64'd0;
      near_setting[7] = {$urandom, $urandom} & MASK42;
      range_setting[7] = {$urandom, $urandom} & MASK42;
      near_setting[8] = 64'd256;
      range_setting[8] = 64'd256 * 40;
      foreach (pressure_of[p]) pressure_of[p] = PRESSURE_NONE;
      pressure_of[2] = HOLD_RECEIVER;
      pressure_of[4] = DRAIN_SENDER;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      span = isqrt(board.near_sq);

      // With the default near distance of 16 units, offsets of 16*k land exactly on
      // the band edges, and one more step pushes the pair into the next band.
      send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 0, 0, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 0, 0, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 16, 0, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 17, 0, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 0, -32, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 0, 0, 48));
      send_request(make_req(0, 0, 1, 100, 100, 100, 51, 100, 100));
      send_request(make_req(0, 0, 1, 0, 0, 0, 80, 0, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 0, 96, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 0, 0, -112));
      send_request(make_req(0, 0, 1, 0, 0, 0, 128, 0, 0));
      send_request(make_req(0, 0, 1, 0, 0, 0, 129, 0, 0));
      send_request(make_req(0, 0, 0, 0, 0, 0, 129, 0, 0));
      send_request(make_req(15, 255, 1, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MAX, COORD_MAX));
      send_request(make_req(15, 255, 1, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MIN));
      send_request(make_req(15, 255, 0, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MIN));
      send_request(make_req(5, 170, 1, 20'h55555, 20'hAAAAA, 20'h55555,
                            20'h55555, 20'hAAAAA, 20'h55555));
      send_request(make_req(10, 85, 1, 20'hAAAAA, 20'h55555, 20'hAAAAA,
                            20'h55555, 20'hAAAAA, 20'h55555));
      send_request(make_req(0, 1, 1, -8, 0, 0, 7, 0, 0));
      send_request(make_req(3, 7, 1, 0, 0, 0, 9, 9, 9));
      send_request(make_req(3, 7, 1, 0, 0, 0, 10, 10, 10));
      idle_gap(1);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_for_changes();
            repeat (SETTLE_CYCLES) @(posedge clock);
            write_register(dstp_pkg::REG_NEAR_DISTANCE_SQ, near_setting[p]);
            write_register(dstp_pkg::REG_MAX_RANGE_SQ, range_setting[p]);
            span = isqrt(board.near_sq);
         end
         run_random(ITEMS_PER_PHASE, pressure_of[p]);
      end

      wait_for_changes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d words over %0d register settings and compared %0d period changes.",
               board.requests_seen, PHASES, board.changes_checked);
      $display("The receiver held off for %0d cycles once; the sender drained the block once.",
               hold_count);
      if (board.mismatches == 0) begin
         $display("distance_send_period_table: match");
      end else begin
         $display("distance_send_period_table: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/dstp_pkg.sv
design/dstp_datapath.sv
design/dstp_ctrl.sv
design/distance_send_period_table.sv
bench/distance_send_period_table_tb.sv
